// ===== design/dsr_pkg.sv =====
// Shared types and constants for the stream-aware RRIP replacement engine.
// Used by the front end, the queue, the back end and the top level.
package dsr_pkg;

    // Item kinds.
    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Configuration register byte addresses.
    localparam logic [1:0] REG_STREAM_WINDOW = 2'd0;

    localparam logic [1:0]  RRPV_MAX     = 2'd3;
    localparam logic [1:0]  RUN_MAX      = 2'd3;
    localparam logic [9:0]  PSEL_MID     = 10'd512;
    localparam logic [9:0]  PSEL_TOP     = 10'd1023;
    localparam logic [3:0]  WINDOW_RESET = 4'd8;
    localparam int          BIP_BITS     = 5;
    localparam int          LINE_SHIFT   = 6;
    localparam int          LINE_W       = 48 - LINE_SHIFT;

    // One accepted item as it travels from front to back.
    typedef struct packed {
        logic        kind;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic        hit;
        logic [47:0] phys_address;
    } item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Per-set stream detector state.
    typedef struct packed {
        logic [LINE_W-1:0] last_line;
        logic [1:0]        stride_run;
        logic              stream_active;
        logic [3:0]        countdown;
    } det_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_EXEC
    } back_state_t;

endpackage

// ===== design/dip_streaming_rrip_replacement_top.sv =====
// Stream-aware RRIP replacement engine with DIP set dueling.
// A victim query passes the front-end register, a queue slot, fetch and execute to done.
// Each item's read-modify-write of the set metadata ends before the back end takes the next.
// Reset: a clearing pass over every set zeroes the metadata; busy stays high meanwhile.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Depends on dsr_pkg, dsr_front, dsr_queue and dsr_back.
module dip_streaming_rrip_replacement_top #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int LEADER_SETS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [10:0] set_index,
    input  logic [3:0]  way_index,
    input  logic        hit,
    input  logic [47:0] phys_address,
    output logic        done,
    output logic [3:0]  victim_way,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dsr_pkg::*;

    item_t      in_item, push_item, head;
    q_status_t  q_stat;
    logic       push, pop, clearing;
    logic [3:0] window_reg;

    assign in_item = '{kind: kind, set_index: set_index, way_index: way_index,
                       hit: hit, phys_address: phys_address};

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_STREAM_WINDOW) ? {28'd0, window_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && (paddr == REG_STREAM_WINDOW))
        begin
            window_reg <= pwdata[3:0];
        end
    end

    dsr_front #(.NUM_SETS(NUM_SETS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .clearing  (clearing),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    dsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    dsr_back #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .LEADER_SETS (LEADER_SETS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream_window (window_reg),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .clearing      (clearing),
        .done          (done),
        .victim_way    (victim_way)
    );

endmodule

// ===== design/dsr_front.sv =====
// Front end: accepts items, reduces the set index modulo the set count.
// Depends on dsr_pkg; feeds dsr_queue.
module dsr_front #(
    parameter int NUM_SETS = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dsr_pkg::item_t    in_item,
    input  logic              clearing,
    input  dsr_pkg::q_status_t q_stat,
    output logic              push,
    output dsr_pkg::item_t    push_item
);
    import dsr_pkg::*;

    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + NUM_SETS - 1) / NUM_SETS;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = 11 + RECIP_W;
    localparam int NS_W        = $clog2(NUM_SETS + 1);
    localparam int QN_W        = 11 + NS_W;

    logic        valid_reg;
    item_t       item_reg;
    logic [10:0] quot_reg;
    logic [PROD_W-1:0] prod;
    logic [QN_W-1:0]   qn;
    logic [11:0]       rem;
    logic              accept;

    // Busy while the back end clears or the held beat cannot move on.
    assign busy   = clearing | (valid_reg & q_stat.full);
    assign accept = start & ~busy;
    assign push   = valid_reg & ~q_stat.full;

    // Quotient by reciprocal multiplication.
    assign prod = PROD_W'(in_item.set_index) * PROD_W'(RECIP);

    // Remainder with one correction step.
    always_comb
    begin
        qn  = QN_W'(quot_reg) * QN_W'(NUM_SETS);
        rem = 12'(item_reg.set_index) - 12'(qn);
        if (rem >= 12'(NUM_SETS))
        begin
            rem = rem - 12'(NUM_SETS);
        end
        push_item           = item_reg;
        push_item.set_index = rem[10:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
            quot_reg <= 11'(prod >> RECIP_SHIFT);
        end
    end

endmodule

// ===== design/dsr_queue.sv =====
// Two-entry queue between the front and back ends.
// Depends on dsr_pkg.
module dsr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dsr_pkg::item_t     push_item,
    input  logic               pop,
    output dsr_pkg::item_t     head,
    output dsr_pkg::q_status_t q_stat
);
    import dsr_pkg::*;

    item_t      slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign head         = slot_reg[rptr_reg];
    assign q_stat.full  = count_reg == 2'd2;
    assign q_stat.empty = count_reg == 2'd0;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/dsr_back.sv =====
// Back end: per-set metadata memory, stream detector, victim search, set dueling.
// Depends on dsr_pkg; takes items from dsr_queue.
module dsr_back #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int LEADER_SETS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         stream_window,
    input  dsr_pkg::item_t     head,
    input  dsr_pkg::q_status_t q_stat,
    output logic               pop,
    output logic               clearing,
    output logic               done,
    output logic [3:0]         victim_way
);
    import dsr_pkg::*;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);

    typedef logic [NUM_WAYS-1:0][1:0] rrpv_row_t;

    // Metadata memories, one row per set.
    rrpv_row_t             rrpv_mem [NUM_SETS];
    logic [NUM_WAYS-1:0]   dead_mem [NUM_SETS];
    det_t                  det_mem  [NUM_SETS];

    back_state_t state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    item_t            cur_reg;
    rrpv_row_t        rrpv_rd_reg;
    logic [NUM_WAYS-1:0] dead_rd_reg;
    det_t             det_rd_reg;
    logic [9:0]       psel_reg, psel_next;
    logic [31:0]      lip_hits_reg, lip_hits_next;
    logic [31:0]      bip_hits_reg, bip_hits_next;
    logic [11:0]      phase_reg, phase_next;
    logic             done_reg;
    logic [3:0]       victim_way_reg, victim_way_next;

    logic             mem_we;
    logic [SET_W-1:0] wr_addr;
    logic [SET_W-1:0] rd_addr;
    rrpv_row_t        rrpv_wr;
    logic [NUM_WAYS-1:0] dead_wr;
    det_t             det_wr;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FETCH;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop      = 1'b0;
        clearing = 1'b0;
        mem_we   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                mem_we   = 1'b1;
            end
            ST_FETCH:
            begin
                pop = ~q_stat.empty;
            end
            ST_EXEC:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    assign rd_addr = SET_W'(head.set_index);

    // Execute: victim search, aging, detector, insertion and duel counters; rows are zeroed while clearing.
    always_comb
    begin
        logic              any_dead, any3, any2, any1;
        logic [WAY_W-1:0]  first_dead, first3;
        logic [1:0]        top, add;
        rrpv_row_t         aged;
        det_t              det;
        logic [LINE_W-1:0] line;
        logic [LINE_W:0]   diff;
        logic              step, way_ok, role_lip, role_bip, lip, streaming;
        logic [1:0]        run_n, ins_rrpv;
        logic              ins_dead;

        rrpv_wr         = rrpv_rd_reg;
        dead_wr         = dead_rd_reg;
        det_wr          = det_rd_reg;
        psel_next       = psel_reg;
        lip_hits_next   = lip_hits_reg;
        bip_hits_next   = bip_hits_reg;
        phase_next      = phase_reg;
        victim_way_next = victim_way_reg;

        // Dead scan and RRPV maximum.
        any_dead   = |dead_rd_reg;
        first_dead = '0;
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (dead_rd_reg[w])
            begin
                first_dead = WAY_W'(w);
            end
            any3 = any3 | (rrpv_rd_reg[w] == 2'd3);
            any2 = any2 | (rrpv_rd_reg[w] == 2'd2);
            any1 = any1 | (rrpv_rd_reg[w] == 2'd1);
        end
        top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
        add = RRPV_MAX - top;
        first3 = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            aged[w] = rrpv_rd_reg[w] + add;
            if (aged[w] == RRPV_MAX)
            begin
                first3 = WAY_W'(w);
            end
        end

        // Stream detector.
        det  = det_rd_reg;
        line = cur_reg.phys_address[47:LINE_SHIFT];
        diff = {1'b0, line} - {1'b0, det.last_line};
        step = (det.last_line != '0) &&
               ((diff == (LINE_W+1)'(1)) || (diff == '1));
        run_n = (det.stride_run == RUN_MAX) ? RUN_MAX : det.stride_run + 2'd1;
        if (step)
        begin
            det.stride_run = run_n;
            if ((run_n == RUN_MAX) && !det.stream_active)
            begin
                det.stream_active = 1'b1;
                det.countdown     = stream_window;
            end
        end
        else
        begin
            det.stride_run    = 2'd0;
            det.stream_active = 1'b0;
            det.countdown     = 4'd0;
        end
        det.last_line = line;
        if (det.stream_active && (det.countdown != 4'd0))
        begin
            det.countdown = det.countdown - 4'd1;
        end
        streaming = det.stream_active && (det.countdown != 4'd0);

        way_ok   = int'(cur_reg.way_index) < NUM_WAYS;
        role_lip = int'(cur_reg.set_index) < LEADER_SETS / 2;
        role_bip = !role_lip && (int'(cur_reg.set_index) < LEADER_SETS);
        lip      = role_lip || (!role_bip && (psel_reg >= PSEL_MID));

        // Insertion choice for a miss fill.
        if (streaming)
        begin
            ins_rrpv = RRPV_MAX;
            ins_dead = 1'b1;
        end
        else
        begin
            ins_dead = 1'b0;
            if (lip)
            begin
                ins_rrpv = RRPV_MAX;
            end
            else
            begin
                ins_rrpv = ((phase_reg + 12'd1) % 12'(1 << BIP_BITS) == 12'd0) ?
                           2'd0 : RRPV_MAX;
            end
        end

        if (cur_reg.kind == KIND_QUERY)
        begin
            if (any_dead)
            begin
                victim_way_next = 4'(first_dead);
            end
            else
            begin
                victim_way_next = 4'(first3);
                rrpv_wr         = aged;
            end
        end
        else
        begin
            det_wr     = det;
            phase_next = phase_reg + 12'd1;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (way_ok && (int'(cur_reg.way_index) == w))
                begin
                    rrpv_wr[w] = cur_reg.hit ? 2'd0 : ins_rrpv;
                    dead_wr[w] = cur_reg.hit ? 1'b0 : ins_dead;
                end
            end
            if (cur_reg.hit)
            begin
                if (role_lip && (lip_hits_reg != '1))
                begin
                    lip_hits_next = lip_hits_reg + 32'd1;
                end
                else if (role_bip && (bip_hits_reg != '1))
                begin
                    bip_hits_next = bip_hits_reg + 32'd1;
                end
            end
            else if (phase_next == 12'd0)
            begin
                // Duel epoch ends: move the selector toward the winner.
                if ((lip_hits_reg > bip_hits_reg) && (psel_reg < PSEL_TOP))
                begin
                    psel_next = psel_reg + 10'd1;
                end
                else if ((bip_hits_reg > lip_hits_reg) && (psel_reg != 10'd0))
                begin
                    psel_next = psel_reg - 10'd1;
                end
                lip_hits_next = '0;
                bip_hits_next = '0;
            end
        end

        if (state_reg == ST_CLEAR)
        begin
            rrpv_wr = '0;
            dead_wr = '0;
            det_wr  = '0;
        end
    end

    assign wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : SET_W'(cur_reg.set_index);

    // Metadata memories: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rrpv_mem[wr_addr] <= rrpv_wr;
            dead_mem[wr_addr] <= dead_wr;
            det_mem[wr_addr]  <= det_wr;
        end
        rrpv_rd_reg <= rrpv_mem[rd_addr];
        dead_rd_reg <= dead_mem[rd_addr];
        det_rd_reg  <= det_mem[rd_addr];
    end

    // Control and global duel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            psel_reg     <= PSEL_MID;
            lip_hits_reg <= '0;
            bip_hits_reg <= '0;
            phase_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            done_reg <= (state_reg == ST_EXEC) && (cur_reg.kind == KIND_QUERY);
            if (state_reg == ST_EXEC)
            begin
                psel_reg     <= psel_next;
                lip_hits_reg <= lip_hits_next;
                bip_hits_reg <= bip_hits_next;
                phase_reg    <= phase_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (state_reg == ST_EXEC)
        begin
            victim_way_reg <= victim_way_next;
        end
    end

    assign done       = done_reg;
    assign victim_way = victim_way_reg;

endmodule
